// ===== rtl/core/order_book_level_table_defines.svh =====
// Assertion macros used by the order book level table controller.
`ifndef ORDER_BOOK_LEVEL_TABLE_DEFINES_SVH
`define ORDER_BOOK_LEVEL_TABLE_DEFINES_SVH

// Check that an antecedent implies a consequent in the same cycle.
`define OBL_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that an antecedent implies a consequent in the next cycle.
`define OBL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/oblt_pkg.sv =====
// Shared types and codes of the order book level table.
`default_nettype none
package oblt_pkg;

   localparam logic [1:0] REQ_CLEAR = 2'd0;
   localparam logic [1:0] REQ_SNAP  = 2'd1;
   localparam logic [1:0] REQ_DELTA = 2'd2;

   localparam logic [2:0] ST_CLEARED  = 3'd0;
   localparam logic [2:0] ST_INSERTED = 3'd1;
   localparam logic [2:0] ST_ADDED    = 3'd2;
   localparam logic [2:0] ST_REMOVED  = 3'd3;
   localparam logic [2:0] ST_IGNORED  = 3'd4;
   localparam logic [2:0] ST_FULL     = 3'd5;

   // Operation the controller asks of one side table.
   typedef enum logic [1:0] {
      OP_NONE,
      OP_CLEAR,
      OP_UPDATE
   } op_type;

   // Commands from controller to datapath.
   typedef struct packed {
      op_type     op;
      logic       is_ask;
      logic       is_snap;
   } cmd_type;

endpackage
`default_nettype wire

// ===== rtl/core/oblt_side.sv =====
// One sorted price-level table built as a chain of compare and shift cells.
`default_nettype none
module oblt_side
   import oblt_pkg::*;
#(
   parameter int DEPTH      = 256,
   parameter int PRICE_BITS = 40,
   parameter int QTY_BITS   = 48,
   parameter bit IS_ASK     = 1'b0
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          clear_en,
   input  wire logic                          eval_en,
   input  wire logic                          commit_en,
   input  wire logic                          is_snap,
   input  wire logic [PRICE_BITS-1:0]         price,
   input  wire logic [QTY_BITS-1:0]           quantity,
   output logic      [2:0]                    status,
   output logic      [$clog2(DEPTH+1)-1:0]    count,
   output logic      [PRICE_BITS-1:0]         best_price,
   output logic      [QTY_BITS-1:0]           best_qty
);

   localparam int CW = $clog2(DEPTH+1);
   localparam logic [QTY_BITS-1:0] QMAX = {QTY_BITS{1'b1}};

   logic [PRICE_BITS-1:0] price_ff [DEPTH];
   logic [QTY_BITS-1:0]   qty_ff   [DEPTH];
   logic [CW-1:0]         fill_ff, fill_in;
   logic [PRICE_BITS-1:0] hold_price_ff;

   // per-cell flags from the compare stage, registered
   logic [DEPTH-1:0] before_ff, equal_ff;
   logic [DEPTH-1:0] before_c, equal_c, valid_c;
   logic [DEPTH-1:0] match_c, shift_c;
   logic [DEPTH-1:0] ins_mask, rm_mask;
   logic [2:0]       status_ff, status_in;
   logic             any_match, full;

   // compare every cell with the incoming price
   always_comb begin
      for (int k = 0; k < DEPTH; k++) begin
         valid_c[k]  = (CW'(k) < fill_ff);
         equal_c[k]  = valid_c[k] && (price_ff[k] == price);
         before_c[k] = valid_c[k] &&
                       (IS_ASK ? (price_ff[k] < price) : (price_ff[k] > price));
      end
   end

   // hold the flags and the price for the commit cycle
   always_ff @(posedge clock) begin
      if (eval_en) begin
         before_ff     <= before_c;
         equal_ff      <= equal_c;
         hold_price_ff <= price;
      end
   end

   // first equal cell: equal and previous cell not equal (cells sorted)
   always_comb begin
      for (int k = 0; k < DEPTH; k++) begin
         match_c[k] = equal_ff[k] && ((k == 0) ? 1'b1 : !equal_ff[(k == 0) ? 0 : k-1]);
         // insert position: snapshot goes past equals, delta before
         shift_c[k] = is_snap ? !(before_ff[k] || equal_ff[k]) : !before_ff[k];
      end
      any_match = |equal_ff;
      full      = (fill_ff == CW'(DEPTH));
      ins_mask  = shift_c;
      // remove: cells from match onward pull from right
      rm_mask   = '0;
      for (int k = 0; k < DEPTH; k++)
         rm_mask[k] = equal_ff[k] || !before_ff[k];
      if (!is_snap && any_match)
         status_in = (quantity == '0) ? ST_REMOVED : ST_ADDED;
      else if (!is_snap && quantity == '0)
         status_in = ST_IGNORED;
      else if (full)
         status_in = ST_FULL;
      else
         status_in = ST_INSERTED;
   end

   always_comb begin
      fill_in = fill_ff;
      if (clear_en)
         fill_in = '0;
      else if (commit_en && status_in == ST_INSERTED)
         fill_in = fill_ff + CW'(1);
      else if (commit_en && status_in == ST_REMOVED)
         fill_in = fill_ff - CW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff   <= '0;
         status_ff <= ST_IGNORED;
      end else begin
         fill_ff <= fill_in;
         if (commit_en)
            status_ff <= status_in;
      end
   end

   // shift, insert, remove or add in each cell
   always_ff @(posedge clock) begin
      if (commit_en) begin
         for (int k = 0; k < DEPTH; k++) begin
            case (status_in)
               ST_INSERTED: begin
                  if (ins_mask[k]) begin
                     if (k == 0 || !ins_mask[(k == 0) ? 0 : k-1]) begin
                        price_ff[k] <= hold_price_ff;
                        qty_ff[k]   <= quantity;
                     end else begin
                        price_ff[k] <= price_ff[(k == 0) ? 0 : k-1];
                        qty_ff[k]   <= qty_ff[(k == 0) ? 0 : k-1];
                     end
                  end
               end
               ST_REMOVED: begin
                  if (rm_mask[k] && k < DEPTH-1) begin
                     price_ff[k] <= price_ff[(k < DEPTH-1) ? k+1 : k];
                     qty_ff[k]   <= qty_ff[(k < DEPTH-1) ? k+1 : k];
                  end
               end
               ST_ADDED: begin
                  if (match_c[k])
                     qty_ff[k] <= (qty_ff[k] > QMAX - quantity) ? QMAX
                                                                : qty_ff[k] + quantity;
               end
               default: ;
            endcase
         end
      end
   end

   assign status     = status_ff;
   assign count      = fill_ff;
   assign best_price = (fill_ff != '0) ? price_ff[0] : '0;
   assign best_qty   = (fill_ff != '0) ? qty_ff[0]   : '0;

endmodule
`default_nettype wire

// ===== rtl/core/oblt_ctrl.sv =====
// Controller: handshake and sequencing of compare, commit and response.
`default_nettype none
module oblt_ctrl
   import oblt_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   req_tvalid,
   output logic        req_tready,
   input  wire logic [1:0] req_type,
   input  wire logic   side,
   output logic        rsp_tvalid,
   input  wire logic   rsp_tready,
   output cmd_type     cmd,
   output logic        eval_en,
   output logic        commit_en,
   output logic        fixed_st_valid,
   output logic [2:0]  fixed_st
);

   typedef enum logic [1:0] {S_IDLE, S_COMMIT, S_RESP} state_type;

   state_type   state_ff;
   cmd_type     cmd_ff;
   logic        fixed_valid_ff;
   logic [2:0]  fixed_ff;
   logic        accept;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE) || (state_ff == S_RESP && rsp_tready);
   assign rsp_tvalid = (state_ff == S_RESP);
   assign eval_en    = accept;
   assign commit_en  = (state_ff == S_COMMIT) && cmd_ff.op == OP_UPDATE;
   assign cmd        = (state_ff == S_COMMIT) ? cmd_ff
                                              : cmd_type'{op: OP_NONE, is_ask: cmd_ff.is_ask,
                                                          is_snap: cmd_ff.is_snap};
   assign fixed_st_valid = fixed_valid_ff;
   assign fixed_st       = fixed_ff;

   // sequence each word through compare, commit and response
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         cmd_ff         <= cmd_type'{op: OP_NONE, is_ask: 1'b0, is_snap: 1'b0};
         fixed_valid_ff <= 1'b0;
         fixed_ff       <= ST_IGNORED;
      end else begin
         case (state_ff)
            S_IDLE, S_RESP: begin
               if (state_ff == S_RESP && rsp_tready)
                  state_ff <= S_IDLE;
               if (accept) begin
                  state_ff       <= S_COMMIT;
                  cmd_ff.is_ask  <= side;
                  cmd_ff.is_snap <= (req_type == REQ_SNAP);
                  case (req_type)
                     REQ_CLEAR: begin
                        cmd_ff.op <= OP_CLEAR; fixed_valid_ff <= 1'b1; fixed_ff <= ST_CLEARED;
                     end
                     REQ_SNAP, REQ_DELTA: begin
                        cmd_ff.op <= OP_UPDATE; fixed_valid_ff <= 1'b0;
                     end
                     default: begin
                        cmd_ff.op <= OP_NONE; fixed_valid_ff <= 1'b1; fixed_ff <= ST_IGNORED;
                     end
                  endcase
               end
            end
            S_COMMIT: state_ff <= S_RESP;
            default:  state_ff <= S_IDLE;
         endcase
      end
   end

   `include "order_book_level_table_defines.svh"
   `OBL_ASSERT_NEXT(a_commit_to_resp, clock, reset, state_ff == S_COMMIT, rsp_tvalid, "no resp")
   `OBL_ASSERT_IMPLY(a_no_accept_commit, clock, reset, state_ff == S_COMMIT, !req_tready, "busy")
   `OBL_ASSERT_NEXT(a_accept_commit, clock, reset, accept, state_ff == S_COMMIT, "no commit")

endmodule
`default_nettype wire

// ===== rtl/core/order_book_level_table.sv =====
// Order book level table: bid and ask sorted level tables with update control.
// Use: send one update word on req_; one result word returns on rsp_.
// req_tdata: req_type, side, price, quantity, from the lowest bit up.
// Every word gives exactly one result: status, both counts and best levels.
// On accept all cells compare with the price and the flags are registered;
// in the commit state the chosen cells shift or update, and the result word
// is then valid in the response state, where the receiver takes it.
// A new word is accepted when the controller is idle or in the same cycle
// the result is taken; no new word is accepted while one is in its commit state.
// The word rate is set by the compare stage then the cell commit stage.
// A receiver stall holds the result and blocks new words until it is taken.
// Reset empties both sides; no clearing pass is needed, cell contents past
// the fill counts are never read.
// Clear empties both sides at once.
`default_nettype none
module order_book_level_table
   import oblt_pkg::*;
#(
   parameter int DEPTH      = 256,
   parameter int PRICE_BITS = 40,
   parameter int QTY_BITS   = 48
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_tvalid,
   output logic      req_tready,
   // req_type[1:0], side, price, quantity; zero filled to bytes
   input  wire logic [((3+PRICE_BITS+QTY_BITS+7)/8)*8-1:0] req_tdata,
   output logic      rsp_tvalid,
   input  wire logic rsp_tready,
   // status[2:0], bid_count, ask_count, best_bid_price, best_bid_qty,
   // best_ask_price, best_ask_qty; zero filled to bytes
   output logic [((3+2*$clog2(DEPTH+1)+2*PRICE_BITS+2*QTY_BITS+7)/8)*8-1:0] rsp_tdata
);

   localparam int CW = $clog2(DEPTH+1);
   localparam int OW = 3+2*CW+2*PRICE_BITS+2*QTY_BITS;
   localparam int OWP = ((OW+7)/8)*8;

   logic [1:0]            req_type;
   logic                  side;
   logic [PRICE_BITS-1:0] price;
   logic [QTY_BITS-1:0]   quantity, qty_ff;
   cmd_type               cmd;
   logic                  eval_en, commit_en, fixed_valid;
   logic [2:0]            fixed_st, bid_st, ask_st, status;
   logic [CW-1:0]         bid_count, ask_count;
   logic [PRICE_BITS-1:0] bbp, bap;
   logic [QTY_BITS-1:0]   bbq, baq;
   logic                  clear_en, last_ask_ff;

   assign req_type = req_tdata[1:0];
   assign side     = req_tdata[2];
   assign price    = req_tdata[3 +: PRICE_BITS];
   assign quantity = req_tdata[3+PRICE_BITS +: QTY_BITS];

   // hold the word payload for the commit cycle
   always_ff @(posedge clock) begin
      if (eval_en) begin
         qty_ff      <= quantity;
         last_ask_ff <= side;
      end
   end

   oblt_ctrl u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready, .req_type, .side,
      .rsp_tvalid, .rsp_tready, .cmd, .eval_en, .commit_en,
      .fixed_st_valid(fixed_valid), .fixed_st
   );

   assign clear_en = (cmd.op == OP_CLEAR);

   oblt_side #(.DEPTH(DEPTH), .PRICE_BITS(PRICE_BITS), .QTY_BITS(QTY_BITS),
               .IS_ASK(1'b0)) u_bid (
      .clock, .reset, .clear_en,
      .eval_en(eval_en && !side),
      .commit_en(commit_en && !cmd.is_ask),
      .is_snap(cmd.is_snap), .price(price), .quantity(qty_ff),
      .status(bid_st), .count(bid_count), .best_price(bbp), .best_qty(bbq)
   );

   oblt_side #(.DEPTH(DEPTH), .PRICE_BITS(PRICE_BITS), .QTY_BITS(QTY_BITS),
               .IS_ASK(1'b1)) u_ask (
      .clock, .reset, .clear_en,
      .eval_en(eval_en && side),
      .commit_en(commit_en && cmd.is_ask),
      .is_snap(cmd.is_snap), .price(price), .quantity(qty_ff),
      .status(ask_st), .count(ask_count), .best_price(bap), .best_qty(baq)
   );

   // pick the status of the side that ran, or the fixed code
   assign status = fixed_valid ? fixed_st : (last_ask_ff ? ask_st : bid_st);

   assign rsp_tdata = OWP'({baq, bap, bbq, bbp, ask_count, bid_count, status});

endmodule
`default_nettype wire
